### rtl/core/pal_pkg.sv
`default_nettype none

package pal_pkg;

    // Default list size
    localparam int CAPACITY_DEF      = 256;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Command codes
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;
    localparam logic [2:0] CMD_PRED   = 3'd5;
    localparam logic [2:0] CMD_SUCC   = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Command word
    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  position;
        logic [31:0] value;
    } t_in;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
        logic [8:0]  found_position;
        logic [8:0]  list_length;
        logic        is_empty;
    } t_out;

endpackage

`default_nettype wire

### rtl/core/positional_array_list_top.sv
// Ordered list of up to CAPACITY elements held in one single-port-read memory.
// Command channel: i_in_valid / o_in_stall carry i_in_word (cmd, position, value).
// Result channel: o_out_valid / i_out_stall carry o_out_word; one result word
// per command word, in command order.
// A command is taken only while the sequencer is idle; it then works alone.
// Clear, bad position, full, unused code and a search of an empty list give their
// result straight from idle. Read fetches one element; insert at count + 1 only
// places the element; insert at p <= count first moves elements p..count up by
// one, from the tail down; delete at p moves elements p+1..count down by one;
// find / predecessor / successor walk the list from the head until they are done.
// The sequencer is idle again, and takes the next command, in the same cycle that
// o_out_valid rises. The memory is walked one element per cycle.
// The result sits in an output register: the next command is accepted while a
// result still waits under i_out_stall; a second finished result then holds in
// the sequencer until the output register frees.
// Reset empties the list (count to zero) and drops any pending result; the
// element memory itself is not cleared and needs no clearing pass.
`default_nettype none

module positional_array_list_top #(
    parameter int CAPACITY      = pal_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = pal_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire pal_pkg::t_in  i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output pal_pkg::t_out      o_out_word
);

    localparam int EW  = ELEMENT_WIDTH;
    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PCW = ((CW > 10) ? CW : 10) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PUT,
        S_DONE
    } t_state;

    // Element memory
    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Sequencer state
    t_state         r_state, n_state;
    logic [2:0]     r_cmd, n_cmd;
    logic [AW-1:0]  r_pos0, n_pos0;
    logic [EW-1:0]  r_value, n_value;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]  r_ra, n_ra;
    logic [AW-1:0]  r_rend, n_rend;
    logic           r_issue, n_issue;
    logic           r_dv, n_dv;
    logic [AW-1:0]  r_da, n_da;
    logic [EW-1:0]  r_prev, n_prev;
    logic [EW-1:0]  r_rv, n_rv;
    logic           r_shit, n_shit;
    pal_pkg::t_out  r_res, n_res;
    logic           r_ov, n_ov;
    pal_pkg::t_out  r_out, n_out;

    // Decode helpers
    logic [63:0]    vwide;
    logic [EW-1:0]  vin;
    logic [PCW-1:0] pos_w;
    logic [PCW-1:0] pos_m1;
    logic [PCW-1:0] cnt_w;
    logic [CW-1:0]  cnt_m1;
    logic           last;
    logic           hit;
    logic [EW-1:0]  del_rv;

    // Pack one result word
    function automatic pal_pkg::t_out make_res(
        input logic [1:0]    st,
        input logic [EW-1:0] rv,
        input logic [CW-1:0] fp,
        input logic [CW-1:0] cnt
    );
        pal_pkg::t_out res;
        logic [63:0]   rvw;
        logic [31:0]   fpw;
        logic [31:0]   cw;
        rvw                = 64'(rv);
        fpw                = 32'(fp);
        cw                 = 32'(cnt);
        res.status         = st;
        res.result_value   = rvw[31:0];
        res.found_position = fpw[8:0];
        res.list_length    = cw[8:0];
        res.is_empty       = (cnt == '0);
        return res;
    endfunction

    assign vwide  = 64'(i_in_word.value);
    assign vin    = vwide[EW-1:0];
    assign pos_w  = PCW'(i_in_word.position);
    assign pos_m1 = pos_w - PCW'(1);
    assign cnt_w  = PCW'(r_cnt);
    assign cnt_m1 = r_cnt - CW'(1);
    assign last   = (r_da == r_rend);
    assign hit    = (r_rd_data == r_value);
    assign del_rv = (r_da == r_pos0) ? r_rd_data : r_rv;

    // Next-state logic of the sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_pos0    = r_pos0;
        n_value   = r_value;
        n_cnt     = r_cnt;
        n_ra      = r_ra;
        n_rend    = r_rend;
        n_issue   = r_issue;
        n_dv      = r_dv;
        n_da      = r_da;
        n_prev    = r_prev;
        n_rv      = r_rv;
        n_shit    = r_shit;
        n_res     = r_res;
        n_ov      = r_ov;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_pos0;
        mem_wdata = r_value;
        mem_raddr = r_ra;

        // Free the output register once taken
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_word.cmd;
                    n_value = vin;
                    n_pos0  = pos_m1[AW-1:0];
                    n_dv    = 1'b0;
                    n_shit  = 1'b0;
                    n_issue = 1'b0;
                    n_state = S_DONE;
                    case (i_in_word.cmd)
                        pal_pkg::CMD_CLEAR: begin
                            n_cnt = '0;
                            n_res = make_res(pal_pkg::ST_OK, '0, '0, '0);
                        end
                        pal_pkg::CMD_INSERT: begin
                            if (pos_w == '0 || pos_w > cnt_w + PCW'(1)) begin
                                n_res = make_res(pal_pkg::ST_BADPOS, '0, '0, r_cnt);
                            end else if (r_cnt == CW'(CAPACITY)) begin
                                n_res = make_res(pal_pkg::ST_FULL, '0, '0, r_cnt);
                            end else if (pos_m1 == cnt_w) begin
                                n_state = S_PUT;
                            end else begin
                                // Walk the tail downwards
                                n_ra    = cnt_m1[AW-1:0];
                                n_rend  = pos_m1[AW-1:0];
                                n_issue = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        pal_pkg::CMD_DELETE,
                        pal_pkg::CMD_READ: begin
                            if (pos_w == '0 || pos_w > cnt_w) begin
                                n_res = make_res(pal_pkg::ST_BADPOS, '0, '0, r_cnt);
                            end else begin
                                n_ra    = pos_m1[AW-1:0];
                                n_rend  = (i_in_word.cmd == pal_pkg::CMD_DELETE) ?
                                          cnt_m1[AW-1:0] : pos_m1[AW-1:0];
                                n_issue = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        pal_pkg::CMD_FIND,
                        pal_pkg::CMD_PRED,
                        pal_pkg::CMD_SUCC: begin
                            if (r_cnt == '0) begin
                                n_res = make_res(pal_pkg::ST_NOTFOUND, '0, '0, r_cnt);
                            end else begin
                                n_ra    = '0;
                                n_rend  = cnt_m1[AW-1:0];
                                n_issue = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                            n_res = make_res(pal_pkg::ST_OK, '0, '0, r_cnt);
                        end
                    endcase
                end
            end

            S_RUN: begin
                // Issue the next read
                if (r_issue) begin
                    mem_raddr = r_ra;
                    n_dv      = 1'b1;
                    n_da      = r_ra;
                    if (r_ra == r_rend) begin
                        n_issue = 1'b0;
                    end else if (r_cmd == pal_pkg::CMD_INSERT) begin
                        n_ra = r_ra - AW'(1);
                    end else begin
                        n_ra = r_ra + AW'(1);
                    end
                end else begin
                    n_dv = 1'b0;
                end

                // Consume the word read last cycle
                if (r_dv) begin
                    n_prev = r_rd_data;
                    case (r_cmd)
                        pal_pkg::CMD_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_da + AW'(1);
                            mem_wdata = r_rd_data;
                            if (last) begin
                                n_state = S_PUT;
                            end
                        end
                        pal_pkg::CMD_DELETE: begin
                            if (r_da == r_pos0) begin
                                n_rv = r_rd_data;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_da - AW'(1);
                                mem_wdata = r_rd_data;
                            end
                            if (last) begin
                                n_cnt   = cnt_m1;
                                n_res   = make_res(pal_pkg::ST_OK, del_rv, '0, cnt_m1);
                                n_state = S_DONE;
                            end
                        end
                        pal_pkg::CMD_READ: begin
                            n_res   = make_res(pal_pkg::ST_OK, r_rd_data, '0, r_cnt);
                            n_state = S_DONE;
                        end
                        pal_pkg::CMD_FIND: begin
                            if (hit) begin
                                n_res   = make_res(pal_pkg::ST_OK, '0,
                                                   CW'(r_da) + CW'(1), r_cnt);
                                n_state = S_DONE;
                            end else if (last) begin
                                n_res   = make_res(pal_pkg::ST_NOTFOUND, '0, '0, r_cnt);
                                n_state = S_DONE;
                            end
                        end
                        pal_pkg::CMD_PRED: begin
                            if (hit && r_da != '0) begin
                                n_res   = make_res(pal_pkg::ST_OK, r_prev, '0, r_cnt);
                                n_state = S_DONE;
                            end else if (last) begin
                                n_res   = make_res(pal_pkg::ST_NOTFOUND, '0, '0, r_cnt);
                                n_state = S_DONE;
                            end
                        end
                        pal_pkg::CMD_SUCC: begin
                            if (r_shit) begin
                                n_res   = make_res(pal_pkg::ST_OK, r_rd_data, '0, r_cnt);
                                n_state = S_DONE;
                            end else if (hit && !last) begin
                                n_shit = 1'b1;
                            end else if (last) begin
                                n_res   = make_res(pal_pkg::ST_NOTFOUND, '0, '0, r_cnt);
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end

                // Drop any reads still in flight once finished
                if (n_state != S_RUN) begin
                    n_issue = 1'b0;
                    n_dv    = 1'b0;
                end
            end

            S_PUT: begin
                // Place the new element
                mem_we    = 1'b1;
                mem_waddr = r_pos0;
                mem_wdata = r_value;
                n_cnt     = r_cnt + CW'(1);
                n_res     = make_res(pal_pkg::ST_OK, '0, '0, r_cnt + CW'(1));
                n_state   = S_DONE;
            end

            S_DONE: begin
                // Hand the result word to the output register
                if (!r_ov || !i_out_stall) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_issue <= n_issue;
            r_dv    <= n_dv;
            r_ov    <= n_ov;
        end
        r_cmd   <= n_cmd;
        r_pos0  <= n_pos0;
        r_value <= n_value;
        r_ra    <= n_ra;
        r_rend  <= n_rend;
        r_da    <= n_da;
        r_prev  <= n_prev;
        r_rv    <= n_rv;
        r_shit  <= n_shit;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Element memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    // Length never runs past the capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("list length beyond capacity");

    // An accepted command keeps the sequencer busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after accepting a command");

    // Failed commands return no element and no position
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != pal_pkg::ST_OK) |->
        (o_out_word.result_value == '0 && o_out_word.found_position == '0))
        else $error("failed command carries a value or position");

    // Memory is only written while a command is at work
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !mem_we)
        else $error("memory written outside a command");

endmodule

`default_nettype wire
